// File: rtl/vl2n_pkg.sv
// Package with shared types and constants for the vector L2 normalizer.
`default_nettype none
package vl2n_pkg;

  localparam int ElemW  = 24;
  localparam int SumW   = 57;
  localparam int RootW  = 29;
  localparam int LenW   = 8;
  localparam int NumW   = 46;
  localparam int QuoW   = 47;
  localparam logic [23:0] OneQ22 = 24'd4194304;

  localparam logic [0:0] KIND_LOAD  = 1'b0;
  localparam logic [0:0] KIND_FETCH = 1'b1;

  localparam logic [0:0] REG_FIRST  = 1'b0;
  localparam logic [0:0] REG_SECOND = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic fetch_start;
    logic sqrt_start;
    logic div_start;
    logic sqrt_step;
    logic div_step;
    logic result_latch;
  } vl2n_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } vl2n_sts_t;

endpackage
`default_nettype wire

// File: rtl/vector_l2_normalizer.sv
// Top level of the vector L2 normalizer.
//   channel  | handshake                | payload
//   in       | in_valid / in_ready      | kind, element
//   out      | out_valid / out_ready    | normalized, position, last, zero_length
//   cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
// A load request writes its element and adds its square to the sum when it is
// accepted. A fetch request passes through a memory read, 29 square-root steps,
// 46 divider steps and the output state before its result is registered.
// Reset is synchronous; counters and sum clear, the element memory does not.
// A finished result waits in the output state while the previous one is still
// unclaimed; no new request is taken until the controller is idle again.
`default_nettype none
module vector_l2_normalizer #(
  parameter int MAX_DIM = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic signed [23:0] element,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      normalized,
  output logic [7:0]              position,
  output logic                    last,
  output logic                    zero_length,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);

  localparam int AW = $clog2(MAX_DIM);

  logic [7:0] first_part_length, second_part_length;
  vl2n_pkg::vl2n_cmd_t cmd;
  vl2n_pkg::vl2n_sts_t sts;
  logic [AW-1:0] load_addr, fetch_addr;
  logic busy;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_part_length  <= 8'd1;
      second_part_length <= 8'd0;
    end else if (cfg_valid) begin
      if (cfg_index == vl2n_pkg::REG_FIRST) first_part_length <= cfg_data;
      else second_part_length <= cfg_data;
    end
  end

  vl2n_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind,
    .vlen({1'b0, first_part_length} + {1'b0, second_part_length}),
    .out_valid, .out_ready, .position, .last, .cmd, .sts,
    .load_addr, .fetch_addr, .busy
  );

  vl2n_datapath #(.AW(AW)) u_dp (
    .clk, .rst, .cmd, .sts, .load_addr, .fetch_addr, .element,
    .result_value(normalized), .result_zero(zero_length)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && in_valid) |-> !in_ready)
    else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_length) |-> (normalized == '0))
    else $error("zero vector gave nonzero");

endmodule
`default_nettype wire

// File: rtl/vl2n_datapath.sv
// Datapath: element memory, square sum, iterative square root and divider.
`default_nettype none
module vl2n_datapath #(
  parameter int AW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire vl2n_pkg::vl2n_cmd_t  cmd,
  output vl2n_pkg::vl2n_sts_t       sts,
  input  wire logic [AW-1:0]        load_addr,
  input  wire logic [AW-1:0]        fetch_addr,
  input  wire logic signed [23:0]   element,
  output logic signed [23:0]        result_value,
  output logic                      result_zero
);

  logic [23:0] mem [2**AW];
  logic [23:0] rd_data;
  logic [vl2n_pkg::SumW-1:0] square_sum;
  logic [23:0] mag_in;
  logic [47:0] sq;
  logic [57:0] sum_wide;

  assign mag_in   = element[23] ? 24'(-element) : 24'(element);
  assign sq       = {24'd0, mag_in} * {24'd0, mag_in};
  assign sum_wide = {1'b0, square_sum} + {10'd0, sq};

  // Element store and registered read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_addr] <= element;
    end
    rd_data <= mem[fetch_addr];
  end

  // Saturating sum of squares.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      square_sum <= '0;
    end else if (cmd.load) begin
      square_sum <= sum_wide[57] ? {vl2n_pkg::SumW{1'b1}} : sum_wide[56:0];
    end
  end

  // Bit-pair square root, one result bit per cycle.
  logic [57:0] rem;
  logic [57:0] sq_val;
  logic [28:0] root;
  logic [4:0]  sq_cnt;
  logic [59:0] trial_rem;
  logic [30:0] trial;
  assign trial_rem = {rem[55:0], sq_val[57:56]} - {29'd0, root, 2'b01};
  assign trial     = 31'd0;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rem    <= '0;
      sq_val <= {1'b0, square_sum};
      root   <= '0;
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      sq_val <= {sq_val[55:0], 2'b00};
      sq_cnt <= sq_cnt + 5'd1;
      if (!trial_rem[59]) begin
        rem  <= trial_rem[57:0];
        root <= {root[27:0], 1'b1};
      end else begin
        rem  <= {rem[55:0], sq_val[57:56]};
        root <= {root[27:0], 1'b0};
      end
    end
  end

  // Restoring divider for |x| * 2^22 / root, one quotient bit per cycle.
  logic        x_neg;
  logic [45:0] num;
  logic [29:0] drem;
  logic [45:0] quo;
  logic [5:0]  dv_cnt;
  logic [30:0] dsub;
  assign dsub = {drem, num[45]} - {2'b00, root};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      x_neg  <= rd_data[23];
      num    <= {(rd_data[23] ? 24'(-rd_data) : rd_data), 22'd0};
      drem   <= '0;
      quo    <= '0;
      dv_cnt <= '0;
    end else if (cmd.div_step) begin
      num    <= {num[44:0], 1'b0};
      dv_cnt <= dv_cnt + 6'd1;
      if (!dsub[30]) begin
        drem <= dsub[29:0];
        quo  <= {quo[44:0], 1'b1};
      end else begin
        drem <= {drem[28:0], num[45]};
        quo  <= {quo[44:0], 1'b0};
      end
    end
  end

  // Completion flags for the controller.
  assign sts = '{sqrt_done: (sq_cnt == 5'd29), div_done: (dv_cnt == 6'd46)};

  // Round half away from zero, clamp, apply sign.
  logic [31:0] rem2;
  logic        round_up;
  logic [46:0] qr;
  logic [23:0] qmag;
  assign rem2     = {1'b0, drem, 1'b0};
  assign round_up = rem2 >= {3'd0, root};
  assign qr       = {1'b0, quo} + {46'd0, round_up};
  assign qmag     = (qr > {23'd0, vl2n_pkg::OneQ22}) ? vl2n_pkg::OneQ22 : qr[23:0];

  always_ff @(posedge clk) begin
    if (cmd.result_latch) begin
      result_zero  <= (root == '0);
      result_value <= (root == '0) ? '0 : (x_neg ? 24'(-qmag) : qmag);
    end
  end

  logic unused;
  assign unused = cmd.fetch_start ^ (|trial);

endmodule
`default_nettype wire

// File: rtl/vl2n_ctrl.sv
// Controller: counters, handshakes and sequencing of the datapath.
`default_nettype none
module vl2n_ctrl #(
  parameter int MAX_DIM = 256,
  parameter int AW = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                kind,
  input  wire logic [8:0]          vlen,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               position,
  output logic                     last,
  output vl2n_pkg::vl2n_cmd_t      cmd,
  input  wire vl2n_pkg::vl2n_sts_t sts,
  output logic [AW-1:0]            load_addr,
  output logic [AW-1:0]            fetch_addr,
  output logic                     busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state, state_next;
  logic [AW:0] load_count;
  logic [AW:0] emit_count;
  logic [AW:0] len;
  logic        accept, is_last, out_take;

  assign len = (int'(vlen) > MAX_DIM) ? (AW+1)'(MAX_DIM) : (AW+1)'(vlen);
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign load_addr  = load_count[AW-1:0];
  assign fetch_addr = emit_count[AW-1:0];
  assign is_last = (emit_count + 1'b1) == len;
  assign busy = (state != S_IDLE);
  // A finished result moves to the output register once that is free.
  assign out_take = (state == S_OUT) && (!out_valid || out_ready);

  // Command decode.
  always_comb begin
    cmd = '0;
    cmd.load = accept && (len != 0) && (kind == vl2n_pkg::KIND_LOAD)
               && (load_count < len);
    cmd.clear = (accept && (len != 0) && (kind == vl2n_pkg::KIND_FETCH)
                 && (emit_count >= len)) || (out_take && is_last);
    cmd.fetch_start = accept && (len != 0) && (kind == vl2n_pkg::KIND_FETCH)
                      && (emit_count < len) && (load_count >= len);
    cmd.sqrt_start = (state == S_READ);
    cmd.sqrt_step  = (state == S_SQRT) && !sts.sqrt_done;
    cmd.div_start  = (state == S_SQRT) && sts.sqrt_done;
    cmd.div_step   = (state == S_DIV) && !sts.div_done;
    cmd.result_latch = out_take;
    state_next = state;
    case (state)
      S_IDLE: if (cmd.fetch_start) state_next = S_READ;
      S_READ: state_next = S_SQRT;
      S_SQRT: if (sts.sqrt_done) state_next = S_DIV;
      S_DIV:  if (sts.div_done) state_next = S_OUT;
      S_OUT:  if (out_take) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State, counters and output flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      load_count <= '0;
      emit_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take) begin
        out_valid <= 1'b1;
        position  <= 8'(emit_count);
        last      <= is_last;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        load_count <= '0;
        emit_count <= '0;
      end else if (cmd.load) begin
        load_count <= load_count + 1'b1;
      end else if (out_take) begin
        emit_count <= emit_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
